// ===== rtl/core/fcf_pkg.sv =====
// shared constants and types for the fir convolution filter
package fcf_pkg;

    localparam int MAX_TAP_COUNT = 4096;
    localparam int SAMPLE_BITS   = 24;
    localparam int COEF_BITS     = 24;

    localparam int ADDR_BITS  = $clog2(MAX_TAP_COUNT);
    localparam int TAP_BITS   = ADDR_BITS + 1;
    localparam int CFG_BITS   = 13;
    localparam int MODE_BITS  = 2;
    localparam int INDEX_BITS = 12;
    localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS   = PROD_BITS + ADDR_BITS;
    localparam int RND_SHIFT  = COEF_BITS - 1;

    localparam logic [MODE_BITS-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_COEF   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROUND,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/fcf_if.sv =====
// channel interfaces for the fir convolution filter
interface fcf_in_if;
    import fcf_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [MODE_BITS-1:0]         mode;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [INDEX_BITS-1:0]        coef_index;
    logic signed [COEF_BITS-1:0]  coef_value;
    logic                         last_in_block;

    modport source (
        output valid, mode, sample_in, coef_index, coef_value, last_in_block,
        input  ready
    );
    modport sink (
        input  valid, mode, sample_in, coef_index, coef_value, last_in_block,
        output ready
    );
endinterface

interface fcf_out_if;
    import fcf_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          block_end;

    modport source (output valid, sample_out, block_end, input ready);
    modport sink (input valid, sample_out, block_end, output ready);
endinterface

interface fcf_cfg_if;
    import fcf_pkg::*;

    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] tap_count;

    modport source (output valid, tap_count, input ready);
    modport sink (input valid, tap_count, output ready);
endinterface

// ===== rtl/core/fir_convolution_filter.sv =====
// direct-form fir filter with circular history and one shared multiply-accumulate
//
//  channel   dir   handshake      payload
//  i_cfg     in    valid/ready    tap_count
//  i_in      in    valid/ready    mode, sample_in, coef_index, coef_value, last_in_block
//  o_out     out   valid/ready    sample_out, block_end
//
//  a sample steps through the mac, round and done states to its result (tap_count capped at 4096);
//  taps go in turn through the single multiplier and the one read port of each store; tap_count 0 passes through
//  coefficient loads and history clears give no result
//  history validity is tracked by a fill count, so reset and clear need no memory sweep
//  input ready is low while a sample is processed; a stalled output holds the last state
//  reset is synchronous, active low
module fir_convolution_filter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fcf_cfg_if.sink   i_cfg,
    fcf_in_if.sink    i_in,
    fcf_out_if.source o_out
);
    import fcf_pkg::*;

    localparam logic [TAP_BITS-1:0] TAP_MAX  = TAP_BITS'(MAX_TAP_COUNT);
    localparam logic [ADDR_BITS-1:0] IDX_TOP = ADDR_BITS'(MAX_TAP_COUNT - 1);
    localparam logic [ACC_BITS-1:0] RND_HALF = ACC_BITS'(1) << (RND_SHIFT - 1);
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    t_state r_state, n_state;

    logic [CFG_BITS-1:0]          r_tap_count;
    logic [ADDR_BITS-1:0]         r_wr_idx;
    logic [TAP_BITS-1:0]          r_fill;
    logic [TAP_BITS-1:0]          r_taps;
    logic [TAP_BITS-1:0]          r_k;
    logic [ADDR_BITS-1:0]         r_idx;
    logic                         r_rd_vld;
    logic                         r_rd_zero;
    logic                         r_mul_vld;
    logic signed [SAMPLE_BITS-1:0] r_hist_rd;
    logic signed [COEF_BITS-1:0]  r_coef_rd;
    logic signed [PROD_BITS-1:0]  r_prod;
    logic signed [ACC_BITS-1:0]   r_acc;
    logic [SAMPLE_BITS-1:0]       r_res;
    logic                         r_end;
    logic                         r_out_vld;
    logic [SAMPLE_BITS-1:0]       r_out_sample;
    logic                         r_out_end;

    logic [SAMPLE_BITS-1:0] r_hist_mem [MAX_TAP_COUNT];
    logic [COEF_BITS-1:0]   r_coef_mem [MAX_TAP_COUNT];

    logic                            w_ready;
    logic                            w_issue;
    logic                            w_out_load;
    logic                            w_in_acc;
    logic [TAP_BITS-1:0]             w_taps_eff;
    logic signed [PROD_BITS-1:0]     w_prod;
    logic [ACC_BITS-1:0]             w_rnd;
    logic signed [ACC_BITS-1:0]      w_shift;
    logic [ACC_BITS-SAMPLE_BITS:0]   w_hi;
    logic [SAMPLE_BITS-1:0]          w_sat;

    assign w_in_acc   = i_in.valid && w_ready;
    assign w_taps_eff = (TAP_BITS'(r_tap_count) > TAP_MAX) ? TAP_MAX : TAP_BITS'(r_tap_count);

    assign w_prod = r_hist_rd * r_coef_rd;

    // round half up, then saturate
    assign w_rnd   = r_acc + RND_HALF;
    assign w_shift = $signed(w_rnd) >>> RND_SHIFT;
    assign w_hi    = w_shift[ACC_BITS-1:SAMPLE_BITS-1];
    always_comb begin
        if ((&w_hi) || !(|w_hi)) begin
            w_sat = w_shift[SAMPLE_BITS-1:0];
        end else if (w_rnd[ACC_BITS-1]) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = SAT_MAX;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_in.mode == MODE_SAMPLE) begin
                    n_state = (w_taps_eff == '0) ? ST_DONE : ST_MAC;
                end
            end
            ST_MAC: begin
                if (!w_issue && !r_rd_vld && !r_mul_vld) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_ready    = 1'b0;
        w_issue    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE:  w_ready = 1'b1;
            ST_MAC:   w_issue = (r_k < r_taps);
            ST_ROUND: w_out_load = 1'b0;
            ST_DONE:  w_out_load = !r_out_vld || o_out.ready;
            default:  w_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap_count <= '0;
            r_wr_idx    <= '0;
            r_fill      <= '0;
            r_rd_vld    <= 1'b0;
            r_mul_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= w_issue;
            r_mul_vld <= r_rd_vld;
            if (i_cfg.valid) begin
                r_tap_count <= i_cfg.tap_count;
            end
            if (w_in_acc && i_in.mode == MODE_SAMPLE && w_taps_eff != '0) begin
                r_wr_idx <= (r_wr_idx == IDX_TOP) ? '0 : r_wr_idx + 1'b1;
                if (r_fill != TAP_MAX) begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (w_in_acc && i_in.mode == MODE_CLEAR) begin
                r_wr_idx <= '0;
                r_fill   <= '0;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in.mode == MODE_SAMPLE) begin
            r_res  <= i_in.sample_in;
            r_end  <= i_in.last_in_block;
            r_idx  <= r_wr_idx;
            r_k    <= '0;
            r_taps <= w_taps_eff;
            r_acc  <= '0;
        end else begin
            if (w_issue) begin
                r_k       <= r_k + 1'b1;
                r_idx     <= (r_idx == '0) ? IDX_TOP : r_idx - 1'b1;
                r_rd_zero <= (r_k >= r_fill);
            end
            if (r_mul_vld) begin
                r_acc <= r_acc + {{(ACC_BITS-PROD_BITS){r_prod[PROD_BITS-1]}}, r_prod};
            end
            if (r_state == ST_ROUND) begin
                r_res <= w_sat;
            end
        end
        r_prod <= r_rd_zero ? '0 : w_prod;
        if (w_out_load) begin
            r_out_sample <= r_res;
            r_out_end    <= r_end;
        end
    end

    // history store
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in.mode == MODE_SAMPLE && w_taps_eff != '0) begin
            r_hist_mem[r_wr_idx] <= i_in.sample_in;
        end
        r_hist_rd <= r_hist_mem[r_idx];
    end

    // coefficient store
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in.mode == MODE_COEF) begin
            r_coef_mem[i_in.coef_index[ADDR_BITS-1:0]] <= i_in.coef_value;
        end
        r_coef_rd <= r_coef_mem[r_k[ADDR_BITS-1:0]];
    end

    assign i_cfg.ready      = 1'b1;
    assign i_in.ready       = w_ready;
    assign o_out.valid      = r_out_vld;
    assign o_out.sample_out = r_out_sample;
    assign o_out.block_end  = r_out_end;

endmodule

// ===== rtl/core/fcf_checker.sv =====
// port checker for the fir convolution filter, with its bind
module fcf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic [fcf_pkg::MODE_BITS-1:0] i_in_mode,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [fcf_pkg::SAMPLE_BITS-1:0] i_out_sample,
    input logic                          i_out_end
);
    import fcf_pkg::*;

    // output held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output dropped before transaction");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_sample) && $stable(i_out_end))
        else $error("stalled output changed");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a sample transaction leaves ready low in the cycle after it
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_mode == MODE_SAMPLE |=> !i_in_ready)
        else $error("ready right after a sample transaction");

endmodule

bind fir_convolution_filter fcf_checker u_fcf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_mode    (i_in.mode),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out),
    .i_out_end    (o_out.block_end)
);
